[design/bpq_pkg.sv]
// Shared constants, codes and link types for the bounded priority queue.
`default_nettype none

package bpq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PRIO_WIDTH = 16;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CAP_W      = 5;
    localparam int LIM_W      = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [1:0] {
        ACT_ENQ  = 2'd0,
        ACT_DEQ  = 2'd1,
        ACT_PEEK = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic                  enq;
        logic                  deq;
        logic [DATA_WIDTH-1:0] data;
        logic [PRIO_WIDTH-1:0] prio;
    } cell_ctrl_t;

    typedef struct packed {
        logic                  valid;
        logic                  keep;
        logic [DATA_WIDTH-1:0] data;
        logic [PRIO_WIDTH-1:0] prio;
    } cell_link_t;

endpackage

`default_nettype wire

[design/bpq_cell.sv]
// One slot of the sorted list: holds an entry, shifts toward or away from the head.
`default_nettype none

module bpq_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bpq_pkg::cell_ctrl_t ctrl,
    input  wire bpq_pkg::cell_link_t left,
    input  wire bpq_pkg::cell_link_t right,
    output bpq_pkg::cell_link_t      link
);

    logic                           valid_reg;
    logic                           valid_next;
    logic [bpq_pkg::DATA_WIDTH-1:0] data_reg;
    logic [bpq_pkg::DATA_WIDTH-1:0] data_next;
    logic [bpq_pkg::PRIO_WIDTH-1:0] prio_reg;
    logic [bpq_pkg::PRIO_WIDTH-1:0] prio_next;
    logic                           keep;

    assign keep = valid_reg && (prio_reg >= ctrl.prio);

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        prio_next  = prio_reg;
        if (ctrl.enq && !keep)
        begin
            if (left.keep)
            begin
                valid_next = 1'b1;
                data_next  = ctrl.data;
                prio_next  = ctrl.prio;
            end
            else
            begin
                valid_next = left.valid;
                data_next  = left.data;
                prio_next  = left.prio;
            end
        end
        else if (ctrl.deq)
        begin
            valid_next = right.valid;
            data_next  = right.data;
            prio_next  = right.prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

    assign link.valid = valid_reg;
    assign link.keep  = keep;
    assign link.data  = data_reg;
    assign link.prio  = prio_reg;

endmodule

`default_nettype wire

[design/bounded_priority_queue_top.sv]
// Top level of the bounded priority queue: cell chain, count, limit and result register.
// The result is registered and valid in the cycle after the input transfer.
// Throughput: one action per cycle while results are taken; each action updates
// every cell of the chain at once, independent of the fill level.
// Reset: asynchronous, active low; empties the queue, sets the limit to 16,
// and drops any pending result.
`default_nettype none

module bounded_priority_queue_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [31:0] data_in,
    input  wire logic [15:0] priority_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      data_out,
    output logic [1:0]       status,
    output logic [4:0]       count,
    output logic             empty_flag,
    output logic             full_flag
);

    localparam logic [bpq_pkg::LIM_W-1:0] DEPTH_LIM = bpq_pkg::LIM_W'(bpq_pkg::DEPTH);

    logic [bpq_pkg::CAP_W-1:0] cap_reg;
    logic [bpq_pkg::CNT_W-1:0] cnt_reg;
    logic [bpq_pkg::CNT_W-1:0] cnt_next;
    logic                      out_valid_reg;
    logic [31:0]               data_out_reg;
    logic [31:0]               data_out_next;
    logic [1:0]                status_reg;
    logic [1:0]                status_next;
    logic [4:0]                count_reg;
    logic                      empty_reg;
    logic                      full_reg;

    logic [bpq_pkg::LIM_W-1:0] cap_ext;
    logic [bpq_pkg::LIM_W-1:0] limit;
    logic                      full_now;
    logic                      empty_now;
    logic                      fire;
    logic                      do_enq;
    logic                      do_deq;

    bpq_pkg::cell_ctrl_t ctrl;
    bpq_pkg::cell_link_t links [bpq_pkg::DEPTH];
    bpq_pkg::cell_link_t head_tie;
    bpq_pkg::cell_link_t tail_tie;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign fire      = in_valid && in_ready;

    assign cap_ext   = bpq_pkg::LIM_W'(cap_reg);
    assign limit     = (cap_ext > DEPTH_LIM) ? DEPTH_LIM : cap_ext;
    assign full_now  = bpq_pkg::LIM_W'(cnt_reg) >= limit;
    assign empty_now = (cnt_reg == '0);

    assign do_enq = fire && (action == bpq_pkg::ACT_ENQ) && !full_now;
    assign do_deq = fire && (action == bpq_pkg::ACT_DEQ) && !empty_now;

    assign ctrl.enq  = do_enq;
    assign ctrl.deq  = do_deq;
    assign ctrl.data = bpq_pkg::DATA_WIDTH'(data_in);
    assign ctrl.prio = bpq_pkg::PRIO_WIDTH'(priority_in);

    assign head_tie = '{valid: 1'b1, keep: 1'b1, data: '0, prio: '0};
    assign tail_tie = '{valid: 1'b0, keep: 1'b0, data: '0, prio: '0};

    for (genvar i = 0; i < bpq_pkg::DEPTH; i++)
    begin : g_cell
        bpq_pkg::cell_link_t left_link;
        bpq_pkg::cell_link_t right_link;
        if (i == 0)
        begin : g_head
            assign left_link = head_tie;
        end
        else
        begin : g_left
            assign left_link = links[i-1];
        end
        if (i == bpq_pkg::DEPTH - 1)
        begin : g_tail
            assign right_link = tail_tie;
        end
        else
        begin : g_right
            assign right_link = links[i+1];
        end
        bpq_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .left  (left_link),
            .right (right_link),
            .link  (links[i])
        );
    end

    always_comb
    begin
        cnt_next      = cnt_reg;
        status_next   = bpq_pkg::ST_OK;
        data_out_next = '0;
        case (action)
            bpq_pkg::ACT_ENQ:
            begin
                if (full_now)
                    status_next = bpq_pkg::ST_FULL;
                else
                    cnt_next = cnt_reg + bpq_pkg::CNT_W'(1);
            end
            bpq_pkg::ACT_DEQ:
            begin
                if (empty_now)
                    status_next = bpq_pkg::ST_EMPTY;
                else
                begin
                    cnt_next      = cnt_reg - bpq_pkg::CNT_W'(1);
                    data_out_next = 32'(links[0].data);
                end
            end
            bpq_pkg::ACT_PEEK:
            begin
                if (empty_now)
                    status_next = bpq_pkg::ST_EMPTY;
                else
                    data_out_next = 32'(links[0].data);
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= bpq_pkg::CAP_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
            if (fire)
            begin
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_out_reg <= data_out_next;
            status_reg   <= status_next;
            count_reg    <= 5'(cnt_next);
            empty_reg    <= (cnt_next == '0);
            full_reg     <= bpq_pkg::LIM_W'(cnt_next) >= limit;
        end
    end

    assign out_valid  = out_valid_reg;
    assign data_out   = data_out_reg;
    assign status     = status_reg;
    assign count      = count_reg;
    assign empty_flag = empty_reg;
    assign full_flag  = full_reg;

endmodule

`default_nettype wire

[design/bpq_checker.sv]
// Port-level checks for the bounded priority queue, bound to the top level.
`default_nettype none

module bpq_port_checks (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] data_out,
    input wire logic [1:0]  status,
    input wire logic [4:0]  count,
    input wire logic        empty_flag,
    input wire logic        full_flag
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_out) && $stable(count))
        else $error("result changed while stalled");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (empty_flag == (count == 5'd0)))
        else $error("empty flag disagrees with count");

    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == bpq_pkg::ST_FULL) |-> full_flag && (data_out == 32'd0))
        else $error("full rejection without full flag");

    a_reject_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == bpq_pkg::ST_EMPTY) |-> empty_flag && (data_out == 32'd0))
        else $error("empty rejection on a non-empty queue");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("transfer produced no result");

endmodule

bind bounded_priority_queue_top bpq_port_checks u_bpq_port_checks (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data_out   (data_out),
    .status     (status),
    .count      (count),
    .empty_flag (empty_flag),
    .full_flag  (full_flag)
);

`default_nettype wire

[tb/sv/bpq_checker.sv]
// Checker for the bounded priority queue: watches all channels, predicts each result, compares.
module bpq_checker
    import bpq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  action,
    input  logic [31:0] data_in,
    input  logic [15:0] priority_in,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] data_out,
    input  logic [1:0]  status,
    input  logic [4:0]  count,
    input  logic        empty_flag,
    input  logic        full_flag,
    output int          mismatches,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] word;
        logic [1:0]            st;
        logic [4:0]            cnt;
        logic                  empty;
        logic                  full;
    } queue_result_t;

    logic [DATA_WIDTH-1:0] held_data [DEPTH];
    logic [PRIO_WIDTH-1:0] held_prio [DEPTH];
    int                    held_cnt = 0;
    logic [CAP_W-1:0]      cap_limit = CAP_RESET;
    queue_result_t         expected_q [$];
    queue_result_t         want;

    initial mismatches = 0;
    initial pending = 0;

    function automatic queue_result_t serve_action(logic [1:0] act,
                                                   logic [DATA_WIDTH-1:0] word,
                                                   logic [PRIO_WIDTH-1:0] prio);
        queue_result_t r;
        int lim;
        int pos;
        lim = (cap_limit > DEPTH) ? DEPTH : int'(cap_limit);
        r = '0;
        r.st = ST_OK;
        case (act)
            ACT_ENQ:
                if (held_cnt >= lim) begin
                    r.st = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < held_cnt && held_prio[pos] >= prio) pos++;
                    for (int i = held_cnt; i > pos; i--) begin
                        held_data[i] = held_data[i-1];
                        held_prio[i] = held_prio[i-1];
                    end
                    held_data[pos] = word;
                    held_prio[pos] = prio;
                    held_cnt++;
                end
            ACT_DEQ:
                if (held_cnt == 0) begin
                    r.st = ST_EMPTY;
                end else begin
                    r.word = held_data[0];
                    for (int i = 0; i + 1 < held_cnt; i++) begin
                        held_data[i] = held_data[i+1];
                        held_prio[i] = held_prio[i+1];
                    end
                    held_cnt--;
                end
            ACT_PEEK:
                if (held_cnt == 0) r.st = ST_EMPTY;
                else r.word = held_data[0];
            default: ;
        endcase
        r.cnt = held_cnt[4:0];
        r.empty = (held_cnt == 0);
        r.full = (held_cnt >= lim);
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
        if (exp_val !== got_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                     exp_val, got_val);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            held_cnt = 0;
            cap_limit = CAP_RESET;
            expected_q.delete();
        end else begin
            if (out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result transfer with none expected, actual data %0h status %0d",
                             $time, data_out, status);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("data_out", want.word, data_out);
                    check_field("status", 32'(want.st), 32'(status));
                    check_field("count", 32'(want.cnt), 32'(count));
                    check_field("empty_flag", 32'(want.empty), 32'(empty_flag));
                    check_field("full_flag", 32'(want.full), 32'(full_flag));
                end
            end
            if (cfg_valid && cfg_ready) cap_limit = cfg_data;
            if (in_valid && in_ready)
                expected_q.push_back(serve_action(action, data_in, priority_in));
        end
        pending = expected_q.size();
    end

endmodule

[tb/sv/tb_bounded_priority_queue_top.sv]
// Testbench top for the bounded priority queue: clock, reset, stimulus and verdict.
module tb_bounded_priority_queue_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bpq_pkg::*;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         HOLD_LEN    = 60;
    localparam int         BURST_LEN   = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  action = ACT_ENQ;
    logic [31:0] data_in = '0;
    logic [15:0] priority_in = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] data_out;
    logic [1:0]  status;
    logic [4:0]  count;
    logic        empty_flag;
    logic        full_flag;

    int   send_idle = 0;
    int   recv_idle = 0;
    int   stall_left = 0;
    int   cycles = 0;
    logic hold_now = 1'b0;
    int   mismatches;
    int   pending;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    bounded_priority_queue_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .data_in     (data_in),
        .priority_in (priority_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_out    (data_out),
        .status      (status),
        .count       (count),
        .empty_flag  (empty_flag),
        .full_flag   (full_flag)
    );

    bpq_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .data_in     (data_in),
        .priority_in (priority_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_out    (data_out),
        .status      (status),
        .count       (count),
        .empty_flag  (empty_flag),
        .full_flag   (full_flag),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    always @(posedge clk)
    begin
        if (hold_now)
        begin
            stall_left = HOLD_LEN;
            hold_now = 1'b0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic send(logic [1:0] act, logic [31:0] word, logic [15:0] prio);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        data_in <= word;
        priority_in <= prio;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_limit(logic [4:0] lim);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= lim;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item(int enq_pct);
        logic [1:0]  act;
        logic [15:0] prio;
        int          r;
        r = $urandom_range(99);
        if (r < enq_pct)
        begin
            act = ACT_ENQ;
        end
        else
        begin
            r = $urandom_range(99);
            act = (r < 72) ? ACT_DEQ : (r < 97) ? ACT_PEEK : ACT_UNUSED;
        end
        case ($urandom_range(2))
            0: prio = 16'($urandom);
            1: prio = 16'($urandom_range(3));
            default: prio = $urandom_range(1) ? 16'hffff : 16'h0000;
        endcase
        send(act, $urandom, prio);
    endtask

    task automatic random_bursts(int bursts);
        for (int b = 0; b < bursts; b++)
        begin
            for (int k = 0; k < BURST_LEN; k++) random_item((b % 2 == 0) ? 75 : 25);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(ACT_PEEK, 32'h0, 16'h0);
        send(ACT_DEQ, 32'h0, 16'h0);
        send(ACT_UNUSED, 32'hffffffff, 16'hffff);
        send(ACT_ENQ, 32'h80000000, 16'h0000);
        send(ACT_ENQ, 32'h7fffffff, 16'hffff);
        send(ACT_ENQ, 32'h00000001, 16'hffff);
        send(ACT_ENQ, 32'hffffffff, 16'h8000);
        send(ACT_PEEK, 32'h0, 16'h0);
        send(ACT_UNUSED, 32'h0, 16'h0);
        repeat (4) send(ACT_DEQ, 32'h0, 16'h0);
        send(ACT_DEQ, 32'h0, 16'h0);

        write_limit(5'd2);
        send(ACT_ENQ, 32'h00000005, 16'h0010);
        send(ACT_ENQ, 32'h00000006, 16'h0020);
        send(ACT_ENQ, 32'h00000007, 16'h0030);
        send(ACT_PEEK, 32'h0, 16'h0);

        write_limit(5'd1);
        send(ACT_ENQ, 32'h00000008, 16'h0040);
        send(ACT_DEQ, 32'h0, 16'h0);
        send(ACT_DEQ, 32'h0, 16'h0);

        write_limit(5'd0);
        send(ACT_ENQ, 32'h00000009, 16'h0050);
        send(ACT_PEEK, 32'h0, 16'h0);

        write_limit(5'd31);
        send_idle = 28;
        recv_idle = 82;
        random_bursts(7);

        write_limit(5'($urandom_range(1, 16)));
        send_idle = 82;
        recv_idle = 28;
        random_bursts(4);
        write_limit(5'($urandom_range(31)));
        random_bursts(3);

        write_limit(5'd16);
        send_idle = 0;
        recv_idle = 0;
        hold_now = 1'b1;
        random_bursts(7);

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
design/bpq_pkg.sv
design/bpq_cell.sv
design/bounded_priority_queue_top.sv
design/bpq_checker.sv
tb/sv/bpq_checker.sv
tb/sv/tb_bounded_priority_queue_top.sv
